### hdl/cld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_pkg
// Shared sizes, codes and types of the capacity-limited demand splitter.
// ----------------------------------------------------------------------------
package cld_pkg;

    localparam int MAX_RESERVOIRS = 8;
    localparam int MASS_BITS      = 40;
    localparam int RESULT_LIMIT   = 8;
    localparam int GROUP_MAX      = (MAX_RESERVOIRS < RESULT_LIMIT) ? MAX_RESERVOIRS
                                                                    : RESULT_LIMIT;

    localparam int SLOT_W   = 3;
    localparam int TYPE_W   = 2;
    localparam int IN_USE_W = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam int IDX_W      = (MAX_RESERVOIRS > 1) ? $clog2(MAX_RESERVOIRS) : 1;
    localparam int CNT_W      = $clog2(MAX_RESERVOIRS + 1);
    localparam int DIV_STEP_W = $clog2(MASS_BITS + 1);

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_DIST   = 2'd1,
        REQ_ENABLE = 2'd2
    } req_t;

    typedef enum logic [0:0] {
        REG_CASCADE = 1'b0,
        REG_IN_USE  = 1'b1
    } reg_idx_t;

    // controls from the sequencer into the reservoir table
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic             upd;
        logic             drop;
        logic             enable;
    } tbl_ctl_t;

endpackage
`default_nettype wire

### hdl/cld_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_req_if / cld_rsp_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface cld_req_if;
    logic                             valid;
    logic                             ready;
    logic [cld_pkg::TYPE_W-1:0]       req_type;
    logic [cld_pkg::SLOT_W-1:0]       slot;
    logic [cld_pkg::MASS_BITS-1:0]    capacity;
    logic [cld_pkg::MASS_BITS-1:0]    drawn_so_far;
    logic [cld_pkg::MASS_BITS-1:0]    demand;

    modport source (output valid, req_type, slot, capacity, drawn_so_far, demand,
                    input ready);
    modport sink   (input valid, req_type, slot, capacity, drawn_so_far, demand,
                    output ready);
endinterface

interface cld_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [cld_pkg::SLOT_W-1:0]       out_slot;
    logic [cld_pkg::MASS_BITS-1:0]    drawn_step;
    logic                             still_available;
    logic [cld_pkg::MASS_BITS-1:0]    unsatisfied;
    logic                             last;

    modport source (output valid, out_slot, drawn_step, still_available, unsatisfied, last,
                    input ready);
    modport sink   (input valid, out_slot, drawn_step, still_available, unsatisfied, last,
                    output ready);
endinterface
`default_nettype wire

### hdl/capacity_limited_demand_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capacity_limited_demand_splitter
// Max-min fair share, or flow-down fill, of a demand over a table of capacity-limited reservoirs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            word
//  req       in   valid/ready          req_type, slot, capacity, drawn_so_far, demand
//  rsp       out  valid/ready          out_slot, drawn_step, still_available,
//                                      unsatisfied, last
//  apb       in   psel/penable/pready  split mode @0x0, reservoirs_in_use @0x4
//
//  load and re-enable words are handled in idle. a distribute word with n reservoirs
//  first counts the live ones, then runs equal-split passes, each a bit-serial
//  divide and a table walk (at most n passes), or a flow-down walk, then
//  reports one result per reservoir.
//  reset clears the table, the available mask and mode; group size resets to 1.
//  req.ready is low from a distribute word until its last result is registered;
//  a stalled rsp holds the result walk.
// ----------------------------------------------------------------------------
module capacity_limited_demand_splitter
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cld_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [cld_pkg::DATA_W-1:0]    pwdata,
    output logic      [cld_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    cld_req_if.sink                            req,
    cld_rsp_if.source                          rsp
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COUNT  = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_FETCH  = 6'b001000,
        ST_APPLY  = 6'b010000,
        ST_REPORT = 6'b100000
    } state_t;

    localparam int MB = cld_pkg::MASS_BITS;

    state_t                              state_reg, state_next;
    logic [cld_pkg::CNT_W-1:0]           walk_reg,  walk_next;
    logic [cld_pkg::CNT_W-1:0]           cnt_reg,   cnt_next;
    logic [MB-1:0]                       rem_reg,   rem_next;
    logic [MB-1:0]                       per_reg,   per_next;
    logic [MB-1:0]                       room_reg,  room_next;
    logic [MB-1:0]                       unsat_reg, unsat_next;
    logic                                again_reg, again_next;

    logic                                ov_reg,     ov_next;
    logic [cld_pkg::SLOT_W-1:0]          oslot_reg,  oslot_next;
    logic [MB-1:0]                       odrawn_reg, odrawn_next;
    logic                                oavail_reg, oavail_next;
    logic [MB-1:0]                       ounsat_reg, ounsat_next;
    logic                                olast_reg,  olast_next;

    logic                                cascade_mode;
    logic [cld_pkg::CNT_W-1:0]           group_n;
    logic [cld_pkg::MAX_RESERVOIRS-1:0]  grp_mask;
    logic [cld_pkg::MAX_RESERVOIRS-1:0]  avail;
    logic [cld_pkg::IDX_W-1:0]           walk_idx;
    logic                                walk_last;
    cld_pkg::tbl_ctl_t                   tbl_ctl;
    logic [MB-1:0]                       rd_cap;
    logic [MB-1:0]                       rd_drawn;
    logic [MB-1:0]                       upd_drawn;
    logic                                div_start;
    logic                                div_done;
    logic [MB-1:0]                       div_quotient;
    logic [MB:0]                         room_diff;
    logic [MB-1:0]                       room_calc;
    logic [MB-1:0]                       x_sel;
    logic                                fits;
    logic [MB-1:0]                       drawn_add;
    logic                                pass_end;

    cld_apb_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cascade_mode (cascade_mode),
        .group_n      (group_n)
    );

    cld_reservoirs u_table
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .load_cap   (req.capacity),
        .load_drawn (req.drawn_so_far),
        .idx        (walk_idx),
        .upd_drawn  (upd_drawn),
        .grp_mask   (grp_mask),
        .rd_cap     (rd_cap),
        .rd_drawn   (rd_drawn),
        .avail      (avail)
    );

    cld_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_next),
        .divisor  (cnt_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        for (int i = 0; i < cld_pkg::MAX_RESERVOIRS; i++)
            grp_mask[i] = (i < int'(group_n));
    end

    assign walk_idx  = walk_reg[cld_pkg::IDX_W-1:0];
    assign walk_last = (walk_reg == (group_n - cld_pkg::CNT_W'(1)));

    // headroom, zero when drawn already exceeds capacity
    assign room_diff = {1'b0, rd_cap} - {1'b0, rd_drawn};
    assign room_calc = room_diff[MB] ? '0 : room_diff[MB-1:0];

    assign x_sel     = cascade_mode ? rem_reg : per_reg;
    assign fits      = room_reg >= x_sel;
    assign drawn_add = rd_drawn + x_sel;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        walk_next   = walk_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        per_next    = per_reg;
        room_next   = room_reg;
        unsat_next  = unsat_reg;
        again_next  = again_reg;
        ov_next     = ov_reg && !rsp.ready;
        oslot_next  = oslot_reg;
        odrawn_next = odrawn_reg;
        oavail_next = oavail_reg;
        ounsat_next = ounsat_reg;
        olast_next  = olast_reg;
        tbl_ctl     = '0;
        upd_drawn   = rd_drawn;
        div_start   = 1'b0;
        pass_end    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.req_type)
                        cld_pkg::REQ_LOAD:
                        begin
                            tbl_ctl.load     = (int'(req.slot) < cld_pkg::MAX_RESERVOIRS);
                            tbl_ctl.load_idx = cld_pkg::IDX_W'(req.slot);
                        end
                        cld_pkg::REQ_ENABLE:
                            tbl_ctl.enable = 1'b1;
                        cld_pkg::REQ_DIST:
                        begin
                            rem_next   = req.demand;
                            walk_next  = '0;
                            cnt_next   = '0;
                            state_next = ST_COUNT;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end

            ST_COUNT:
            begin
                cnt_next  = cnt_reg + cld_pkg::CNT_W'(avail[walk_idx]);
                walk_next = walk_reg + cld_pkg::CNT_W'(1);
                if (walk_last)
                begin
                    walk_next = '0;
                    priority if (cnt_next == '0)
                    begin
                        unsat_next = rem_reg;
                        state_next = ST_REPORT;
                    end
                    else if (rem_reg == '0)
                    begin
                        unsat_next = '0;
                        state_next = ST_REPORT;
                    end
                    else if (cascade_mode)
                        state_next = ST_FETCH;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    per_next   = div_quotient;
                    rem_next   = '0;
                    again_next = 1'b0;
                    walk_next  = '0;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                if (avail[walk_idx])
                begin
                    room_next  = room_calc;
                    state_next = ST_APPLY;
                end
                else
                    pass_end = 1'b1;
            end

            ST_APPLY:
            begin
                if (fits)
                begin
                    tbl_ctl.upd = 1'b1;
                    upd_drawn   = drawn_add;
                end
                else
                begin
                    // drain and drop this reservoir
                    tbl_ctl.upd  = 1'b1;
                    tbl_ctl.drop = 1'b1;
                    upd_drawn    = rd_cap;
                    cnt_next     = cnt_reg - cld_pkg::CNT_W'(1);
                end

                if (cascade_mode)
                begin
                    if (fits)
                    begin
                        rem_next   = '0;
                        unsat_next = '0;
                        walk_next  = '0;
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        rem_next = rem_reg - room_reg;
                        pass_end = 1'b1;
                    end
                end
                else
                begin
                    if (!fits)
                    begin
                        rem_next   = rem_reg + (per_reg - room_reg);
                        again_next = 1'b1;
                    end
                    pass_end = 1'b1;
                end
            end

            ST_REPORT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next     = 1'b1;
                    oslot_next  = cld_pkg::SLOT_W'(walk_reg);
                    odrawn_next = rd_drawn;
                    oavail_next = avail[walk_idx];
                    olast_next  = walk_last;
                    ounsat_next = walk_last ? unsat_reg : '0;
                    if (walk_last)
                    begin
                        walk_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        walk_next = walk_reg + cld_pkg::CNT_W'(1);
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        // one reservoir done: step the walk, or end the pass after the last one
        if (pass_end)
        begin
            if (!walk_last)
            begin
                walk_next  = walk_reg + cld_pkg::CNT_W'(1);
                state_next = ST_FETCH;
            end
            else
            begin
                walk_next = '0;
                if (!cascade_mode && again_next && (cnt_next != '0))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    unsat_next = (cnt_next == '0) ? rem_next : '0;
                    state_next = ST_REPORT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
            cnt_reg   <= '0;
            again_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            cnt_reg   <= cnt_next;
            again_reg <= again_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        per_reg    <= per_next;
        room_reg   <= room_next;
        unsat_reg  <= unsat_next;
        oslot_reg  <= oslot_next;
        odrawn_reg <= odrawn_next;
        oavail_reg <= oavail_next;
        ounsat_reg <= ounsat_next;
        olast_reg  <= olast_next;
    end

    assign rsp.valid           = ov_reg;
    assign rsp.out_slot        = oslot_reg;
    assign rsp.drawn_step      = odrawn_reg;
    assign rsp.still_available = oavail_reg;
    assign rsp.unsatisfied     = ounsat_reg;
    assign rsp.last            = olast_reg;

endmodule
`default_nettype wire

### hdl/cld_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_apb_regs
// APB register file: split mode and group size, with group size saturation.
// ----------------------------------------------------------------------------
module cld_apb_regs
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cld_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [cld_pkg::DATA_W-1:0]   pwdata,
    output logic      [cld_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic                              cascade_mode,
    output logic      [cld_pkg::CNT_W-1:0]    group_n
);

    logic                            mode_reg,   mode_next;
    logic [cld_pkg::IN_USE_W-1:0]    in_use_reg, in_use_next;
    cld_pkg::reg_idx_t               reg_idx;
    logic                            wr_en;

    assign reg_idx = cld_pkg::reg_idx_t'(paddr[cld_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        in_use_next = in_use_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                cld_pkg::REG_CASCADE: mode_next   = pwdata[0];
                cld_pkg::REG_IN_USE:  in_use_next = pwdata[cld_pkg::IN_USE_W-1:0];
                default:              mode_next   = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            cld_pkg::REG_CASCADE: prdata = cld_pkg::DATA_W'(mode_reg);
            cld_pkg::REG_IN_USE:  prdata = cld_pkg::DATA_W'(in_use_reg);
            default:              prdata = '0;
        endcase
    end

    // zero counts as one, large counts clip to the table size
    always_comb
    begin
        priority if (in_use_reg == '0)
            group_n = cld_pkg::CNT_W'(1);
        else if (int'(in_use_reg) > cld_pkg::GROUP_MAX)
            group_n = cld_pkg::CNT_W'(cld_pkg::GROUP_MAX);
        else
            group_n = cld_pkg::CNT_W'(in_use_reg);
    end

    assign cascade_mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            in_use_reg <= cld_pkg::IN_USE_W'(1);
        end
        else
        begin
            mode_reg   <= mode_next;
            in_use_reg <= in_use_next;
        end
    end

endmodule
`default_nettype wire

### hdl/cld_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_divider
// Bit-serial restoring divider: mass word over live reservoir count.
// ----------------------------------------------------------------------------
module cld_divider
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [cld_pkg::MASS_BITS-1:0]   dividend,
    input  wire logic [cld_pkg::CNT_W-1:0]       divisor,
    output logic                                 done,
    output logic      [cld_pkg::MASS_BITS-1:0]   quotient
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [cld_pkg::DIV_STEP_W-1:0]     step_reg, step_next;
    logic [cld_pkg::MASS_BITS-1:0]      quo_reg,  quo_next;
    logic [cld_pkg::CNT_W-1:0]          part_reg, part_next;
    logic [cld_pkg::CNT_W-1:0]          dsr_reg,  dsr_next;
    logic [cld_pkg::CNT_W:0]            trial;
    logic [cld_pkg::CNT_W:0]            diff;
    logic                               ge;

    always_comb
    begin
        trial = {part_reg, quo_reg[cld_pkg::MASS_BITS-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        dsr_next  = dsr_reg;

        priority if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            part_next = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor
            part_next = ge ? diff[cld_pkg::CNT_W-1:0] : trial[cld_pkg::CNT_W-1:0];
            quo_next  = {quo_reg[cld_pkg::MASS_BITS-2:0], ge};
            step_next = step_reg + cld_pkg::DIV_STEP_W'(1);
            if (step_reg == cld_pkg::DIV_STEP_W'(cld_pkg::MASS_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### hdl/cld_reservoirs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cld_reservoirs
// Reservoir table: capacity, drawn amount and available bit per entry.
// ----------------------------------------------------------------------------
module cld_reservoirs
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cld_pkg::tbl_ctl_t                     ctl,
    input  wire logic [cld_pkg::MASS_BITS-1:0]         load_cap,
    input  wire logic [cld_pkg::MASS_BITS-1:0]         load_drawn,
    input  wire logic [cld_pkg::IDX_W-1:0]             idx,
    input  wire logic [cld_pkg::MASS_BITS-1:0]         upd_drawn,
    input  wire logic [cld_pkg::MAX_RESERVOIRS-1:0]    grp_mask,
    output logic      [cld_pkg::MASS_BITS-1:0]         rd_cap,
    output logic      [cld_pkg::MASS_BITS-1:0]         rd_drawn,
    output logic      [cld_pkg::MAX_RESERVOIRS-1:0]    avail
);

    logic [cld_pkg::MASS_BITS-1:0]       cap_reg   [cld_pkg::MAX_RESERVOIRS];
    logic [cld_pkg::MASS_BITS-1:0]       drawn_reg [cld_pkg::MAX_RESERVOIRS];
    logic [cld_pkg::MAX_RESERVOIRS-1:0]  avail_reg, avail_next;

    always_comb
    begin
        avail_next = avail_reg;
        priority if (ctl.enable)
            avail_next = grp_mask;
        else if (ctl.drop)
            avail_next[idx] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '0;
            for (int i = 0; i < cld_pkg::MAX_RESERVOIRS; i++)
            begin
                cap_reg[i]   <= '0;
                drawn_reg[i] <= '0;
            end
        end
        else
        begin
            avail_reg <= avail_next;
            if (ctl.load)
            begin
                cap_reg[ctl.load_idx]   <= load_cap;
                drawn_reg[ctl.load_idx] <= load_drawn;
            end
            if (ctl.upd)
                drawn_reg[idx] <= upd_drawn;
        end
    end

    assign rd_cap   = cap_reg[idx];
    assign rd_drawn = drawn_reg[idx];
    assign avail    = avail_reg;

endmodule
`default_nettype wire

### test/capacity_limited_demand_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capacity_limited_demand_splitter_tb
// Sends load, distribute and re-enable words to the splitter under several
// register settings and idle patterns. A mirror of the reservoir table works
// out every draw report, and each result word is checked field by field.
// ----------------------------------------------------------------------------
module capacity_limited_demand_splitter_tb;

    localparam int MAX_RESERVOIRS = cld_pkg::MAX_RESERVOIRS;
    localparam int MASS_BITS      = cld_pkg::MASS_BITS;
    localparam int GROUP_MAX      = cld_pkg::GROUP_MAX;
    localparam int SLOT_W         = cld_pkg::SLOT_W;
    localparam int TYPE_W         = cld_pkg::TYPE_W;
    localparam int IN_USE_W       = cld_pkg::IN_USE_W;
    localparam int ADDR_W         = cld_pkg::ADDR_W;
    localparam int DATA_W         = cld_pkg::DATA_W;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_PRINTED  = 40;

    localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;
    localparam logic [ADDR_W-1:0] CASCADE_ADDR = 3'h0;
    localparam logic [ADDR_W-1:0] IN_USE_ADDR  = 3'h4;

    typedef logic [MASS_BITS-1:0] mass_t;

    localparam mass_t MASS_MAX = '1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        mass_t             drawn;
        logic              available;
        mass_t             unsatisfied;
        logic              last;
    } draw_report_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cld_req_if req_bus ();
    cld_rsp_if rsp_bus ();

    // mirror of the reservoir table and registers
    mass_t                     cap_mirror [MAX_RESERVOIRS];
    mass_t                     drawn_mirror [MAX_RESERVOIRS];
    logic [MAX_RESERVOIRS-1:0] avail_mirror;
    logic                      cascade_cfg;
    logic [IN_USE_W-1:0]       in_use_cfg;
    draw_report_t              expected_draws [$];

    int mismatches      = 0;
    int reports_checked = 0;
    int cycle_count     = 0;
    int words_sent [4]  = '{0, 0, 0, 0};
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int tx_calm         = 0;
    int rx_calm         = 0;

    capacity_limited_demand_splitter u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_bus),
        .rsp     (rsp_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d reports still due",
                     cycle_count, expected_draws.size());
            $display("capacity_limited_demand_splitter: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input mass_t got, input mass_t want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns  %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic int group_count();
        int n;
        n = int'(in_use_cfg);
        if (n < 1)
            n = 1;
        if (n > GROUP_MAX)
            n = GROUP_MAX;
        return n;
    endfunction

    function automatic mass_t headroom(input int i);
        return (cap_mirror[i] > drawn_mirror[i]) ? cap_mirror[i] - drawn_mirror[i] : '0;
    endfunction

    // spreads a demand over the live reservoirs, returns what is left unserved once none is live
    function automatic mass_t split_demand(input mass_t demand);
        int                        n;
        logic [MAX_RESERVOIRS-1:0] grp;
        logic [MAX_RESERVOIRS-1:0] live;
        mass_t                     rem;
        mass_t                     per;
        mass_t                     room;
        logic                      again;
        logic                      done;
        n = group_count();
        for (int i = 0; i < MAX_RESERVOIRS; i++)
            grp[i] = (i < n);
        live = avail_mirror & grp;
        rem  = demand;
        if (live == '0)
            return demand;
        if (demand == '0)
            return '0;
        if (cascade_cfg)
        begin
            done = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (live[i] && !done)
                begin
                    room = headroom(i);
                    if (room >= rem)
                    begin
                        drawn_mirror[i] += rem;
                        rem  = '0;
                        done = 1'b1;
                    end
                    else
                    begin
                        rem -= room;
                        drawn_mirror[i] = cap_mirror[i];
                        live[i] = 1'b0;
                    end
                end
            end
        end
        else
        begin
            again = 1'b1;
            // re-split the summed shortfall until no reservoir runs dry
            while (again && live != '0)
            begin
                per   = rem / mass_t'($countones(live));
                again = 1'b0;
                rem   = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (live[i])
                    begin
                        room = headroom(i);
                        if (room >= per)
                            drawn_mirror[i] += per;
                        else
                        begin
                            rem += per - room;
                            drawn_mirror[i] = cap_mirror[i];
                            live[i] = 1'b0;
                            again   = 1'b1;
                        end
                    end
                end
            end
        end
        avail_mirror = (avail_mirror & ~grp) | live;
        return (live == '0) ? rem : '0;
    endfunction

    task automatic apply_word(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                              input mass_t capacity, input mass_t drawn, input mass_t demand);
        int           n;
        mass_t        unsat;
        draw_report_t r;
        n = group_count();
        words_sent[kind]++;
        case (kind)
            cld_pkg::REQ_LOAD:
            begin
                cap_mirror[slot]   = capacity;
                drawn_mirror[slot] = drawn;
            end
            cld_pkg::REQ_ENABLE:
            begin
                for (int i = 0; i < MAX_RESERVOIRS; i++)
                    avail_mirror[i] = (i < n);
            end
            cld_pkg::REQ_DIST:
            begin
                unsat = split_demand(demand);
                for (int i = 0; i < n; i++)
                begin
                    r.slot        = i[SLOT_W-1:0];
                    r.drawn       = drawn_mirror[i];
                    r.available   = avail_mirror[i];
                    r.last        = (i == n - 1);
                    r.unsatisfied = r.last ? unsat : '0;
                    expected_draws.insert(expected_draws.size(), r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_word(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                             input mass_t capacity, input mass_t drawn, input mass_t demand);
        if (tx_calm > 0)
            tx_calm--;
        else if ($urandom_range(15, 0) == 0)
            tx_calm = $urandom_range(30, 5);
        else
        begin
            while (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct)
            begin
                req_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.slot         <= slot;
        req_bus.capacity     <= capacity;
        req_bus.drawn_so_far <= drawn;
        req_bus.demand       <= demand;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        apply_word(kind, slot, capacity, drawn, demand);
    endtask

    // drop valid and let every due report and any trailing table write finish
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_registers();
        logic [DATA_W-1:0] readback;
        apb_read(CASCADE_ADDR, readback);
        if (readback != {{(DATA_W - 1){1'b0}}, cascade_cfg})
            report_mismatch("split mode readback", mass_t'(readback), mass_t'(cascade_cfg));
        apb_read(IN_USE_ADDR, readback);
        if (readback != {{(DATA_W - IN_USE_W){1'b0}}, in_use_cfg})
            report_mismatch("reservoirs_in_use readback", mass_t'(readback), mass_t'(in_use_cfg));
    endtask

    task automatic set_config(input logic mode, input logic [IN_USE_W-1:0] count);
        apb_write(CASCADE_ADDR, {{(DATA_W - 1){1'b0}}, mode});
        cascade_cfg = mode;
        apb_write(IN_USE_ADDR, {{(DATA_W - IN_USE_W){1'b0}}, count});
        in_use_cfg = count;
        check_registers();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic check_report();
        draw_report_t want;
        if (expected_draws.size() == 0)
            report_mismatch("result word with nothing due", rsp_bus.drawn_step, '0);
        else
        begin
            want = expected_draws.pop_front();
            reports_checked++;
            if (rsp_bus.out_slot !== want.slot)
                report_mismatch("out_slot", mass_t'(rsp_bus.out_slot), mass_t'(want.slot));
            if (rsp_bus.drawn_step !== want.drawn)
                report_mismatch($sformatf("slot %0d drawn_step", want.slot),
                                rsp_bus.drawn_step, want.drawn);
            if (rsp_bus.still_available !== want.available)
                report_mismatch($sformatf("slot %0d still_available", want.slot),
                                mass_t'(rsp_bus.still_available), mass_t'(want.available));
            if (rsp_bus.unsatisfied !== want.unsatisfied)
                report_mismatch($sformatf("slot %0d unsatisfied", want.slot),
                                rsp_bus.unsatisfied, want.unsatisfied);
            if (rsp_bus.last !== want.last)
                report_mismatch($sformatf("slot %0d last", want.slot),
                                mass_t'(rsp_bus.last), mass_t'(want.last));
        end
    endtask

    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready)
                check_report();
            if (rx_calm > 0)
            begin
                rx_calm--;
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                if ($urandom_range(31, 0) == 0)
                    rx_calm = $urandom_range(40, 8);
                rsp_bus.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------
    function automatic mass_t rand_mass();
        return {8'($urandom_range(255, 0)), $urandom()};
    endfunction

    function automatic mass_t random_capacity();
        case ($urandom_range(3, 0))
            0:       return rand_mass();
            3:       return mass_t'($urandom_range(1000, 0));
            default: return rand_mass() >> $urandom_range(36, 4);
        endcase
    endfunction

    function automatic mass_t random_drawn(input mass_t cap);
        logic [MASS_BITS:0] span;
        case ($urandom_range(4, 0))
            0:       return '0;
            1:       return rand_mass();
            default:
            begin
                span = {1'b0, cap} + 1'b1;
                return mass_t'({1'b0, rand_mass()} % span);
            end
        endcase
    endfunction

    // demand sized against the headroom that is live right now
    function automatic mass_t random_demand();
        logic [63:0] total;
        logic [63:0] pick;
        total = '0;
        for (int i = 0; i < group_count(); i++)
            if (avail_mirror[i])
                total += 64'(headroom(i));
        case ($urandom_range(5, 0))
            0:       pick = 64'($urandom_range(64, 0));
            1:       pick = {24'b0, rand_mass()} % (total + 1);
            2:       pick = total;
            3:       pick = total + 64'($urandom_range(5000, 1));
            4:       pick = 64'(rand_mass());
            default: pick = ($urandom_range(1, 0) == 0) ? '0 : 64'(rand_mass() >> 20);
        endcase
        if (pick > 64'(MASS_MAX))
            pick = 64'(MASS_MAX);
        return mass_t'(pick);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        check_registers();
        // nothing is available after reset, the whole demand comes back
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, MASS_MAX);
        // slot 0 holds zero capacity, so it drains at once
        send_word(cld_pkg::REQ_ENABLE, '0, '0, '0, '0);
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, mass_t'(12345));
        wait_idle();
    endtask

    task automatic test_equal_split();
        // a count above the table size saturates to the full group
        set_config(1'b0, 4'd15);
        send_word(cld_pkg::REQ_LOAD, 3'd0, MASS_MAX, '0, '0);
        send_word(cld_pkg::REQ_LOAD, 3'd1, mass_t'(1000), '0, '0);
        send_word(cld_pkg::REQ_LOAD, 3'd2, mass_t'(3000), mass_t'(500), '0);
        send_word(cld_pkg::REQ_LOAD, 3'd3, mass_t'(100), mass_t'(250), '0);
        send_word(cld_pkg::REQ_LOAD, 3'd4, mass_t'(7), '0, '0);
        send_word(cld_pkg::REQ_LOAD, 3'd5, {1'b1, {(MASS_BITS - 1){1'b0}}},
                  {1'b0, {(MASS_BITS - 1){1'b1}}}, '0);
        send_word(cld_pkg::REQ_LOAD, 3'd6, mass_t'(50000), '0, '0);
        send_word(cld_pkg::REQ_LOAD, 3'd7, MASS_MAX, MASS_MAX, '0);
        send_word(cld_pkg::REQ_ENABLE, '0, '0, '0, '0);
        // small demand leaves a remainder that is dropped
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, mass_t'(13));
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, mass_t'(60000));
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, '0);
        send_word(REQ_RESERVED, 3'd7, MASS_MAX, MASS_MAX, MASS_MAX);
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, MASS_MAX);
        wait_idle();
    endtask

    task automatic test_flow_down();
        set_config(1'b1, 4'd3);
        send_word(cld_pkg::REQ_LOAD, 3'd0, mass_t'(100), '0, '0);
        send_word(cld_pkg::REQ_LOAD, 3'd1, mass_t'(300), mass_t'(400), '0);
        send_word(cld_pkg::REQ_LOAD, 3'd2, mass_t'(500), mass_t'(20), '0);
        send_word(cld_pkg::REQ_ENABLE, '0, '0, '0, '0);
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, mass_t'(150));
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, mass_t'(2000));
        // every reservoir is dry now
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, mass_t'(10));
        wait_idle();
    endtask

    task automatic test_group_edges();
        set_config(1'b0, 4'd8);
        send_word(cld_pkg::REQ_ENABLE, '0, '0, '0, '0);
        wait_idle();
        // a count of zero acts as a group of one; slots above keep their bits
        set_config(1'b1, 4'd0);
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, MASS_MAX);
        wait_idle();
        set_config(1'b0, 4'd8);
        send_word(cld_pkg::REQ_DIST, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic run_segment(input int words);
        int    n;
        int    left;
        int    pick;
        mass_t cap;
        n    = group_count();
        left = words;
        // well-formed opening: fill the group, then bring it on line
        for (int i = 0; i < n && left > 1; i++)
        begin
            cap = random_capacity();
            send_word(cld_pkg::REQ_LOAD, i[SLOT_W-1:0], cap, random_drawn(cap), rand_mass());
            left--;
        end
        send_word(cld_pkg::REQ_ENABLE, 3'($urandom_range(7, 0)), rand_mass(), rand_mass(),
                  rand_mass());
        left--;
        while (left > 0)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
            begin
                send_word(cld_pkg::REQ_DIST, 3'($urandom_range(7, 0)), rand_mass(),
                          rand_mass(), random_demand());
                left--;
            end
            else if (pick < 75)
            begin
                cap = random_capacity();
                send_word(cld_pkg::REQ_LOAD, 3'($urandom_range(7, 0)), cap, random_drawn(cap),
                          rand_mass());
                left--;
            end
            else if (pick < 88)
            begin
                send_word(cld_pkg::REQ_ENABLE, 3'($urandom_range(7, 0)), rand_mass(),
                          rand_mass(), rand_mass());
                left--;
            end
            else
                send_word(REQ_RESERVED, 3'($urandom_range(7, 0)), rand_mass(), rand_mass(),
                          rand_mass());
        end
    endtask

    task automatic test_random_traffic();
        int   idle_pct [4]  = '{0, 50, 0, 31};
        int   stall_pct [4] = '{0, 0, 50, 31};
        logic mode;
        logic [IN_USE_W-1:0] count;
        for (int p = 0; p < 4; p++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                wait_idle();
                mode = ((p + s) % 2 == 1);
                if (s == 0)
                    count = (p % 2 == 0) ? 4'd8 : 4'd1;
                else
                    count = 4'($urandom_range(15, 0));
                set_config(mode, count);
                tx_idle_pct  = idle_pct[p];
                rx_stall_pct = stall_pct[p];
                run_segment(14);
            end
        end
        wait_idle();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_bus.valid        = 1'b0;
        req_bus.req_type     = '0;
        req_bus.slot         = '0;
        req_bus.capacity     = '0;
        req_bus.drawn_so_far = '0;
        req_bus.demand       = '0;
        for (int i = 0; i < MAX_RESERVOIRS; i++)
        begin
            cap_mirror[i]   = '0;
            drawn_mirror[i] = '0;
        end
        avail_mirror = '0;
        cascade_cfg  = 1'b0;
        in_use_cfg   = 4'd1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_equal_split();
        test_flow_down();
        test_group_edges();
        test_random_traffic();

        wait_idle();
        $display("sent %0d loads, %0d distributes, %0d re-enables, %0d reserved words",
                 words_sent[cld_pkg::REQ_LOAD], words_sent[cld_pkg::REQ_DIST],
                 words_sent[cld_pkg::REQ_ENABLE], words_sent[REQ_RESERVED]);
        $display("checked %0d draw reports over both split modes and group sizes 1 to 8",
                 reports_checked);
        if (mismatches == 0)
            $display("capacity_limited_demand_splitter: match");
        else
            $display("capacity_limited_demand_splitter: mismatch");
        $finish;
    end

endmodule
